[src/cpvp_pkg.sv]
// Package: item types, register indexes and arithmetic constants of the cascade controller.
package cpvp_pkg;

	typedef struct packed {
		logic signed [15:0] measured_angle;
		logic signed [15:0] target_angle;
		logic signed [15:0] measured_velocity;
	} tick_item_t;

	typedef struct packed {
		logic signed [15:0] drive_voltage;
		logic        [7:0]  pwm_duty;
		logic               forward;
	} drive_item_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_UPPER    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_LOWER    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_RATIO   = 3'd6;

	// shared multiplier operand widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int ACC_W   = MUL_A_W + MUL_B_W;

	// floor(z/5) = (z * RECIP5) >> 24 for z < 2^22
	localparam logic [MUL_B_W-1:0] RECIP5     = 24'd3355444;
	localparam int                 RECIP5_SH  = 24;
	// deadband quotient clamp: 5 * 2^17 before the divide by five
	localparam int                 DQ_W       = 21;
	localparam logic signed [DQ_W-1:0] DQ_LIM = 21'sd655360;
	localparam int                 QM_W       = 18;
	// floor(z/3) = (z * RECIP3) >> 16 for z < 2^15
	localparam logic [14:0]        RECIP3     = 15'd21846;

endpackage

[src/cascade_position_velocity_pi.sv]
// Top level: cascade position/velocity PI controller on one shared multiplier.
//
//  channel  | dir | handshake           | payload
//  tick     | in  | tick_valid/stall    | tick  (measured_angle, target_angle, measured_velocity)
//  drive    | out | drive_valid/stall   | drive (drive_voltage, pwm_duty, forward)
//  cfg      | in  | cfg_we              | cfg_idx, cfg_data
//
// An item steps through the states in order from acceptance to the output register, and
// ST_POS and ST_VT run only when the outer loop runs; the next item is taken only back in
// idle, and the single multiplier is used up to six times per item.
// tick_stall is high from acceptance until the result is moved to the output register.
// The output register holds a result while drive_stall is high; the next item is taken
// meanwhile and waits in its last step only if the register is still occupied.
// Reset restores register defaults and clears the integrator, velocity target and phase.
module cascade_position_velocity_pi #(
	parameter int SIGNAL_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 tick_valid,
	output logic                                 tick_stall,
	input  cpvp_pkg::tick_item_t                 tick,
	output logic                                 drive_valid,
	input  logic                                 drive_stall,
	output cpvp_pkg::drive_item_t                drive,
	input  logic                                 cfg_we,
	input  logic [cpvp_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [cpvp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import cpvp_pkg::*;

	localparam logic signed [ACC_W-1:0] SIG_MAX =
		{{(ACC_W-SIGNAL_BITS+1){1'b0}}, {(SIGNAL_BITS-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SIG_MIN = ~SIG_MAX;
	localparam logic signed [ACC_W-1:0] I32_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACC_W-1:0] I32_MIN = ~I32_MAX;

	typedef enum logic [15:0] {
		ST_IDLE = 16'h0001,
		ST_POS  = 16'h0002,
		ST_VT   = 16'h0004,
		ST_VERR = 16'h0008,
		ST_INTM = 16'h0010,
		ST_INTA = 16'h0020,
		ST_PM   = 16'h0040,
		ST_PA   = 16'h0080,
		ST_IM   = 16'h0100,
		ST_IA   = 16'h0200,
		ST_VS   = 16'h0400,
		ST_DM   = 16'h0800,
		ST_DQ   = 16'h1000,
		ST_DR   = 16'h2000,
		ST_DC   = 16'h4000,
		ST_FIN  = 16'h8000
	} state_t;

	function automatic logic signed [SIGNAL_BITS-1:0] sat_sig(input logic signed [ACC_W-1:0] x);
		if (x > SIG_MAX)
			return SIG_MAX[SIGNAL_BITS-1:0];
		else if (x < SIG_MIN)
			return SIG_MIN[SIGNAL_BITS-1:0];
		else
			return x[SIGNAL_BITS-1:0];
	endfunction

	state_t state_q;

	logic [15:0] pos_gain_q, vel_gain_q, int_gain_q, sample_period_q;
	logic [14:0] dead_upper_q, dead_lower_q;
	logic [7:0]  outer_ratio_q;
	logic [7:0]  phase_q;

	tick_item_t                    tick_q;
	logic signed [SIGNAL_BITS-1:0] vt_q, ve_q, v_q;
	logic signed [31:0]            integ_q;
	logic signed [ACC_W-1:0]       prod_q, acc_q;
	logic [DQ_W-1:0]               z_q;
	logic                          neg_q;
	logic signed [15:0]            d_q;

	logic                          out_valid_q;
	drive_item_t                   out_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;

	logic signed [ACC_W-1:0] vdiff, isum, ysh;
	logic signed [DQ_W-1:0]  yc;
	logic [QM_W-1:0]         qm;
	logic signed [19:0]      qs, dd, up20, low20;
	logic signed [15:0]      dband;
	logic [16:0]             mag;
	logic [24:0]             m255;
	logic [14:0]             z3;
	logic [29:0]             q3;
	logic [7:0]              duty;
	logic [8:0]              phase_inc;
	logic [8:0]              ratio;
	logic                    out_free;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_POS: begin
				mul_a = MUL_A_W'(17'(tick_q.target_angle) - 17'(tick_q.measured_angle));
				mul_b = {{(MUL_B_W-16){1'b0}}, pos_gain_q};
			end
			ST_INTM: begin
				mul_a = MUL_A_W'(ve_q);
				mul_b = {{(MUL_B_W-16){1'b0}}, sample_period_q};
			end
			ST_PM: begin
				mul_a = MUL_A_W'(ve_q);
				mul_b = {{(MUL_B_W-16){1'b0}}, vel_gain_q};
			end
			ST_IM: begin
				mul_a = MUL_A_W'(integ_q);
				mul_b = {{(MUL_B_W-16){1'b0}}, int_gain_q};
			end
			ST_DM: begin
				mul_a = MUL_A_W'(v_q);
				mul_b = MUL_B_W'(16'(signed'({1'b0, dead_upper_q})) -
					16'(signed'({1'b0, dead_lower_q})));
			end
			ST_DR: begin
				mul_a = {{(MUL_A_W-DQ_W){1'b0}}, z_q};
				mul_b = RECIP5;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		vdiff = ACC_W'(vt_q) - ACC_W'(tick_q.measured_velocity);
		isum  = ACC_W'(integ_q) + prod_q;
		ysh   = prod_q >>> 9;
		if (ysh > ACC_W'(DQ_LIM))
			yc = DQ_LIM;
		else if (ysh < -ACC_W'(DQ_LIM))
			yc = -DQ_LIM;
		else
			yc = ysh[DQ_W-1:0];

		qm    = prod_q[RECIP5_SH +: QM_W];
		qs    = neg_q ? -20'(qm) : 20'(qm);
		up20  = 20'(dead_upper_q);
		low20 = 20'(dead_lower_q);
		if (v_q > 0) begin
			dd = low20 + qs;
			if (dd > up20)
				dd = up20;
		end else if (v_q < 0) begin
			dd = qs - low20;
			if (dd < -up20)
				dd = -up20;
		end else begin
			dd = '0;
		end
		if (dd > 20'sd32767)
			dband = 16'sh7fff;
		else if (dd < -20'sd32768)
			dband = 16'sh8000;
		else
			dband = dd[15:0];

		mag  = d_q[15] ? 17'(-18'(d_q)) : 17'(d_q);
		m255 = (25'(mag) << 8) - 25'(mag);
		z3   = m255[24:10];
		q3   = 30'(z3) * 30'(RECIP3);
		duty = (q3[29:16] > 14'd255) ? 8'd255 : q3[23:16];

		phase_inc = 9'(phase_q) + 9'd1;
		ratio     = (outer_ratio_q == 8'd0) ? 9'd1 : 9'(outer_ratio_q);
		out_free  = !out_valid_q || !drive_stall;
	end

	assign tick_stall  = (state_q != ST_IDLE);
	assign drive_valid = out_valid_q;
	assign drive       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			pos_gain_q      <= 16'd640;
			vel_gain_q      <= 16'd461;
			int_gain_q      <= 16'd512;
			sample_period_q <= 16'd655;
			dead_upper_q    <= 15'd3072;
			dead_lower_q    <= 15'd0;
			outer_ratio_q   <= 8'd1;
			phase_q         <= '0;
			vt_q            <= '0;
			integ_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_POS_GAIN:      pos_gain_q      <= cfg_data;
					REG_VEL_GAIN:      vel_gain_q      <= cfg_data;
					REG_INT_GAIN:      int_gain_q      <= cfg_data;
					REG_SAMPLE_PERIOD: sample_period_q <= cfg_data;
					REG_DEAD_UPPER:    dead_upper_q    <= cfg_data[14:0];
					REG_DEAD_LOWER:    dead_lower_q    <= cfg_data[14:0];
					REG_OUTER_RATIO:   outer_ratio_q   <= cfg_data[7:0];
					default: ;
				endcase
			end

			// in the last step the output register is reloaded below instead
			if (out_valid_q && !drive_stall && state_q != ST_FIN)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (tick_valid)
						state_q <= (phase_q == 8'd0) ? ST_POS : ST_VERR;
				end
				ST_POS:  state_q <= ST_VT;
				ST_VT: begin
					vt_q    <= sat_sig(prod_q >>> 8);
					state_q <= ST_VERR;
				end
				ST_VERR: state_q <= ST_INTM;
				ST_INTM: state_q <= ST_INTA;
				ST_INTA: begin
					if (isum > I32_MAX)
						integ_q <= I32_MAX[31:0];
					else if (isum < I32_MIN)
						integ_q <= I32_MIN[31:0];
					else
						integ_q <= isum[31:0];
					state_q <= ST_PM;
				end
				ST_PM:   state_q <= ST_PA;
				ST_PA:   state_q <= ST_IM;
				ST_IM:   state_q <= ST_IA;
				ST_IA:   state_q <= ST_VS;
				ST_VS:   state_q <= ST_DM;
				ST_DM:   state_q <= ST_DQ;
				ST_DQ:   state_q <= ST_DR;
				ST_DR:   state_q <= ST_DC;
				ST_DC:   state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						phase_q     <= (phase_inc >= ratio) ? 8'd0 : phase_inc[7:0];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (tick_valid)
					tick_q <= tick;
			end
			ST_POS, ST_INTM, ST_PM, ST_IM, ST_DM, ST_DR: prod_q <= mul_a * mul_b;
			ST_VERR: ve_q  <= sat_sig(vdiff);
			ST_PA:   acc_q <= prod_q;
			ST_IA:   acc_q <= acc_q + (prod_q >>> 16);
			ST_VS:   v_q   <= sat_sig(acc_q >>> 8);
			ST_DQ: begin
				neg_q <= yc[DQ_W-1];
				z_q   <= yc[DQ_W-1] ? DQ_W'(-yc + DQ_W'(4)) : DQ_W'(yc);
			end
			ST_DC:   d_q   <= dband;
			ST_FIN: begin
				if (out_free) begin
					out_q.drive_voltage <= d_q;
					out_q.pwm_duty      <= duty;
					out_q.forward       <= (d_q > 16'sd0);
				end
			end
			default: ;
		endcase
	end

endmodule
